/* hdl/log_band_noise_floor_endpoint_core_macros.svh */
// Assertion macros used by the checker file of the band level and endpoint block.
// No dependencies; include by bare file name.
`ifndef LOG_BAND_NOISE_FLOOR_ENDPOINT_CORE_MACROS_SVH
`define LOG_BAND_NOISE_FLOOR_ENDPOINT_CORE_MACROS_SVH

// Overlapping implication check, sampled on the rising clock edge, off during reset
`define LBNF_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication check
`define LBNF_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/lbnf_pkg.sv */
// Package for the band level, noise floor and word endpoint block.
// Holds widths, reset values, register indexes and the log2 level function.
package lbnf_pkg;

  localparam int unsigned BinsDefault = 20;
  localparam int unsigned PowerW      = 32;
  localparam int unsigned LevelW      = 8;
  localparam int unsigned BandW       = 6;
  localparam int unsigned EnergyW     = 14;
  localparam int unsigned ThreshW     = 13;
  localparam int unsigned FramesW     = 5;
  localparam int unsigned SilenceW    = 8;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 13;

  localparam logic [LevelW-1:0]   FloorInit   = 8'd192;
  localparam logic [LevelW-1:0]   FloorMax    = 8'd255;
  localparam logic [SilenceW-1:0] SilenceMax  = 8'd255;
  localparam logic [FramesW-1:0]  WordMax     = 5'd31;

  localparam logic [ThreshW-1:0]  VoiceOnRst  = 13'd200;
  localparam logic [ThreshW-1:0]  SilenceRst  = 13'd150;
  localparam logic [FramesW-1:0]  MinWordRst  = 5'd5;
  localparam logic [FramesW-1:0]  MaxWordRst  = 5'd25;
  localparam logic [SilenceW-1:0] EndSilRst   = 8'd15;
  localparam logic [SilenceW-1:0] DropSilRst  = 8'd20;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_VOICE_ON   = 3'd0,
    CFG_SILENCE    = 3'd1,
    CFG_MIN_WORD   = 3'd2,
    CFG_MAX_WORD   = 3'd3,
    CFG_END_SIL    = 3'd4,
    CFG_DROP_SIL   = 3'd5
  } cfg_idx_e;

  // Log2 of small powers, scaled by 8
  function automatic logic [LevelW-1:0] small_log(input logic [3:0] p);
    logic [LevelW-1:0] r;
    case (p)
      4'd0:    r = 8'd0;
      4'd1:    r = 8'd0;
      4'd2:    r = 8'd8;
      4'd3:    r = 8'd12;
      4'd4:    r = 8'd16;
      4'd5:    r = 8'd18;
      4'd6:    r = 8'd20;
      4'd7:    r = 8'd22;
      4'd8:    r = 8'd24;
      default: r = 8'd0;
    endcase
    return r;
  endfunction

  // Log2 scaled by 8: msb position in the top five bits, next three bits as mantissa
  function automatic logic [LevelW-1:0] log_level(input logic [PowerW-1:0] p);
    logic [4:0]        msb;
    logic [PowerW-1:0] norm;
    msb = 5'd0;
    for (int i = 0; i < PowerW; i++) begin
      if (p[i]) begin
        msb = 5'(i);
      end
    end
    norm = p << (5'd31 - msb);
    if (p <= 32'd8) begin
      return small_log(p[3:0]);
    end
    return {msb, norm[30:28]};
  endfunction

endpackage

/* hdl/log_band_noise_floor_endpoint_core.sv */
// Top level of the band level, noise floor and word endpoint block.
// Depends on lbnf_pkg.
//
// Takes one band power per transaction and returns one result per transaction,
// BINS bands making a frame. Throughput is one band per clock cycle unless
// stalled. The first stage does the log2 priority encode and normalising shift,
// the second the per-band floor read, subtract and floor update, the frame
// energy sum and, on the last band, the word endpoint counters. The floor table
// lives in flip-flops and resets to 192 in every band. Results are held in an
// output register, so a stalled output still lets one new band enter the first
// stage. Configuration writes are to be made only while no band is in flight.
module log_band_noise_floor_endpoint_core
  import lbnf_pkg::*;
#(
  parameter int unsigned BINS = BinsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // input channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [PowerW-1:0]   band_power_i,
  // output channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [LevelW-1:0]   level_o,
  output logic [BandW-1:0]    band_index_o,
  output logic                frame_end_o,
  output logic [EnergyW-1:0]  frame_energy_o,
  output logic                captured_o,
  output logic                word_dropped_o,
  output logic                word_done_o,
  output logic [FramesW-1:0]  word_frames_o
);

  localparam int unsigned IdxW = (BINS > 1) ? $clog2(BINS) : 1;
  localparam logic [BandW-1:0] LastBand = BandW'(BINS - 1);

  // configuration registers
  logic [ThreshW-1:0]  voice_on_q, silence_lvl_q;
  logic [FramesW-1:0]  min_word_q, max_word_q;
  logic [SilenceW-1:0] end_sil_q, drop_sil_q;

  // pipeline control
  logic a_valid_q, out_valid_q;
  logic out_ld, a_ld, b_fire;
  logic [LevelW-1:0] lg_q;

  // block state
  logic [LevelW-1:0]   floor_q [BINS];
  logic [BandW-1:0]    band_cnt_q, band_cnt_d;
  logic [EnergyW-1:0]  energy_sum_q, energy_sum_d;
  logic [EnergyW-1:0]  prev_energy_q, prev_energy_d;
  logic [FramesW-1:0]  word_len_q, word_len_d;
  logic [SilenceW-1:0] sil_cnt_q, sil_cnt_d;

  // second stage values
  logic [BandW-1:0]    idx;
  logic [LevelW-1:0]   fl, lvl, fl_d;
  logic                last;
  logic [EnergyW-1:0]  energy_all;
  logic                cap, dropped, done;
  logic [FramesW-1:0]  wl1, wl2, wframes;
  logic [SilenceW-1:0] sc1, sc2, sc3;

  // result register
  logic [LevelW-1:0]   level_q;
  logic [BandW-1:0]    band_index_q;
  logic                frame_end_q, captured_q, dropped_q, done_q;
  logic [EnergyW-1:0]  energy_q;
  logic [FramesW-1:0]  wframes_q;

  // Write configuration registers; unknown indexes are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      voice_on_q    <= VoiceOnRst;
      silence_lvl_q <= SilenceRst;
      min_word_q    <= MinWordRst;
      max_word_q    <= MaxWordRst;
      end_sil_q     <= EndSilRst;
      drop_sil_q    <= DropSilRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_VOICE_ON: voice_on_q    <= cfg_data_i;
        CFG_SILENCE:  silence_lvl_q <= cfg_data_i;
        CFG_MIN_WORD: min_word_q    <= cfg_data_i[FramesW-1:0];
        CFG_MAX_WORD: max_word_q    <= cfg_data_i[FramesW-1:0];
        CFG_END_SIL:  end_sil_q     <= cfg_data_i[SilenceW-1:0];
        CFG_DROP_SIL: drop_sil_q    <= cfg_data_i[SilenceW-1:0];
        default: ;
      endcase
    end
  end

  // Advance the pipeline when the result register is free or being drained
  assign out_ld     = !out_valid_q || !out_stall_i;
  assign a_ld       = !a_valid_q || out_ld;
  assign b_fire     = a_valid_q && out_ld;
  assign in_stall_o = !a_ld;

  // First stage: log2 level of the band power
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (a_ld) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ld && in_valid_i) begin
      lg_q <= log_level(band_power_i);
    end
  end

  // Second stage: floor subtract and adaptation, clamp band index to the last band
  always_comb begin
    idx  = ({1'b0, band_cnt_q} >= (BandW + 1)'(BINS)) ? LastBand : band_cnt_q;
    last = (idx == LastBand);
    fl   = floor_q[idx[IdxW-1:0]];
    lvl  = (lg_q > fl) ? (lg_q - fl) : '0;
    fl_d = fl;
    if (prev_energy_q < EnergyW'(silence_lvl_q)) begin
      if (lg_q > fl && fl < FloorMax) begin
        fl_d = fl + 8'd1;
      end else if (lg_q < fl) begin
        fl_d = fl - 8'd1;
      end
    end
    energy_all = energy_sum_q + EnergyW'(lvl);
  end

  // Word endpoint: capture, silence count, drop check, done check in that order
  always_comb begin
    cap = last && (energy_all > EnergyW'(voice_on_q));
    wl1 = word_len_q;
    sc1 = sil_cnt_q;
    if (cap) begin
      wl1 = (word_len_q < WordMax) ? word_len_q + 5'd1 : word_len_q;
      sc1 = '0;
    end
    sc2 = ((energy_all < EnergyW'(silence_lvl_q)) && sc1 < SilenceMax) ? sc1 + 8'd1 : sc1;
    dropped = 1'b0;
    wl2 = wl1;
    sc3 = sc2;
    if (sc2 >= drop_sil_q && wl1 < min_word_q) begin
      dropped = (wl1 != '0);
      wl2 = '0;
      sc3 = '0;
    end
    done    = 1'b0;
    wframes = '0;
    if (wl2 >= max_word_q || (sc3 >= end_sil_q && wl2 >= min_word_q)) begin
      done    = 1'b1;
      wframes = wl2;
    end
    dropped = dropped && last;
    done    = done && last;
    wframes = last ? wframes : '0;

    // next state
    if (last) begin
      band_cnt_d    = '0;
      energy_sum_d  = '0;
      prev_energy_d = energy_all;
      word_len_d    = done ? '0 : wl2;
      sil_cnt_d     = done ? '0 : sc3;
    end else begin
      band_cnt_d    = idx + 6'd1;
      energy_sum_d  = energy_all;
      prev_energy_d = prev_energy_q;
      word_len_d    = word_len_q;
      sil_cnt_d     = sil_cnt_q;
    end
  end

  // Hold block state; update once per band leaving the second stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      band_cnt_q    <= '0;
      energy_sum_q  <= '0;
      prev_energy_q <= '0;
      word_len_q    <= '0;
      sil_cnt_q     <= '0;
      for (int i = 0; i < BINS; i++) begin
        floor_q[i] <= FloorInit;
      end
    end else if (b_fire) begin
      band_cnt_q                 <= band_cnt_d;
      energy_sum_q               <= energy_sum_d;
      prev_energy_q              <= prev_energy_d;
      word_len_q                 <= word_len_d;
      sil_cnt_q                  <= sil_cnt_d;
      floor_q[idx[IdxW-1:0]]     <= fl_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ld) begin
      out_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_fire) begin
      level_q      <= lvl;
      band_index_q <= idx;
      frame_end_q  <= last;
      energy_q     <= last ? energy_all : '0;
      captured_q   <= cap;
      dropped_q    <= dropped;
      done_q       <= done;
      wframes_q    <= wframes;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign level_o        = level_q;
  assign band_index_o   = band_index_q;
  assign frame_end_o    = frame_end_q;
  assign frame_energy_o = energy_q;
  assign captured_o     = captured_q;
  assign word_dropped_o = dropped_q;
  assign word_done_o    = done_q;
  assign word_frames_o  = wframes_q;

endmodule

/* hdl/lbnf_checker.sv */
// Port-level checker for the band level and endpoint block, bound to the top level.
// Depends on lbnf_pkg and log_band_noise_floor_endpoint_core_macros.svh.
`include "log_band_noise_floor_endpoint_core_macros.svh"

module lbnf_checker
  import lbnf_pkg::*;
#(
  parameter int unsigned BINS = BinsDefault
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic [LevelW-1:0]   level_o,
  input logic [BandW-1:0]    band_index_o,
  input logic                frame_end_o,
  input logic [EnergyW-1:0]  frame_energy_o,
  input logic                captured_o,
  input logic                word_dropped_o,
  input logic                word_done_o,
  input logic [FramesW-1:0]  word_frames_o
);

  localparam logic [BandW-1:0] LastBand = BandW'(BINS - 1);

  // A stalled transaction holds its level and band position
  `LBNF_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(level_o) && $stable(band_index_o), "stalled result changed")

  // Frame end flags exactly the last band of a frame
  `LBNF_ASSERT_IMP(a_frame_end_last, clk_i, rst_ni, out_valid_o, frame_end_o == (band_index_o == LastBand), "frame end not on last band")

  // Frame-level outputs stay quiet inside a frame
  `LBNF_ASSERT_IMP(a_mid_frame_quiet, clk_i, rst_ni, out_valid_o && !frame_end_o, frame_energy_o == '0 && !captured_o && !word_dropped_o && !word_done_o, "frame result inside a frame")

  // A word length is only reported with a finished word
  `LBNF_ASSERT_IMP(a_frames_with_done, clk_i, rst_ni, out_valid_o && !word_done_o, word_frames_o == '0, "word frames without word done")

endmodule

bind log_band_noise_floor_endpoint_core lbnf_checker #(.BINS(BINS)) u_lbnf_checker (.*);
